// ===== hdl/pes_pkg.sv =====
// pes_pkg: shared types, register index codes and Q16.16 helper functions
// for the particle Euler step block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pes_pkg;

	typedef logic signed [31:0] q_t;

	localparam int unsigned DT_W = 17;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned FRAC_W = 16;
	localparam q_t Q_ONE = 32'sd65536;
	localparam q_t Q_MAX = 32'sh7FFFFFFF;
	localparam q_t Q_MIN = 32'sh80000000;

	typedef enum logic [0:0] {
		CFG_TIME_STEP = 1'b0,
		CFG_GRAVITY   = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [DT_W-1:0] time_step;
		q_t              gravity_accel;
	} cfg_t;

	// Tail of the datapath handed to the output stage
	typedef struct packed {
		logic               valid;
		logic               alive;
		q_t                 life;
		q_t                 pos_x;
		q_t                 pos_y;
		q_t                 pos_z;
		logic signed [63:0] prod_x;
		logic signed [63:0] prod_y;
		logic signed [63:0] prod_z;
	} tail_t;

	function automatic q_t sat_wide(input logic signed [63:0] v);
		q_t r;
		if (v > 64'sd2147483647) begin
			r = Q_MAX;
		end else if (v < -64'sd2147483648) begin
			r = Q_MIN;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Q16.16 product: floor(p / 2^16), then saturate
	function automatic q_t qnorm(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> FRAC_W;
		return sat_wide(s);
	endfunction

	function automatic q_t add_sat(input q_t a, input q_t b);
		logic signed [32:0] s;
		q_t r;
		s = {a[31], a} + {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

	function automatic q_t sub_sat(input q_t a, input q_t b);
		logic signed [32:0] s;
		q_t r;
		s = {a[31], a} - {b[31], b};
		if (s[32] != s[31]) begin
			r = s[32] ? Q_MIN : Q_MAX;
		end else begin
			r = s[31:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/particle_euler_step_top.sv =====
// particle_euler_step_top: top level of the particle Euler step block.
// Depends on pes_pkg, pes_cfg and pes_pipe.
`timescale 1ns / 1ps
`default_nettype none

// One particle word per start pulse, one result word per particle. The block
// is a fixed six-stage pipeline: a word taken at start passes stages S1 to S5
// and the output register to the result ports with done high, and a new word may enter
// every cycle, so busy is always low. done is high for one cycle only and
// the result is gone after it; the receiver must take it then. The depth is
// set by the multiply chain: velocity*dt alongside mass*gravity, then that *dt,
// then the drag factor product, each with a register behind it. Expired
// particles (life_left - time_step <= 0) come out with alive low, the
// saturated remaining life and zero position and velocity. Write time_step
// and gravity_accel only while nothing is in flight.

module particle_euler_step_top
	import pes_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  start,
	output logic                       busy,
	input  wire q_t                    life_left,
	input  wire q_t                    pos_x,
	input  wire q_t                    pos_y,
	input  wire q_t                    pos_z,
	input  wire q_t                    vel_x,
	input  wire q_t                    vel_y,
	input  wire q_t                    vel_z,
	input  wire q_t                    acc_x,
	input  wire q_t                    acc_y,
	input  wire q_t                    acc_z,
	input  wire q_t                    mass,
	input  wire q_t                    drag,
	output logic                       done,
	output logic                       alive,
	output q_t                         new_life_left,
	output q_t                         new_pos_x,
	output q_t                         new_pos_y,
	output q_t                         new_pos_z,
	output q_t                         new_vel_x,
	output q_t                         new_vel_y,
	output q_t                         new_vel_z
);

	cfg_t  cfg;
	tail_t tail;

	// pipeline never stalls
	assign busy = 1'b0;

	pes_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pes_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_vld    (start && !busy),
		.life_left (life_left),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.vel_x     (vel_x),
		.vel_y     (vel_y),
		.vel_z     (vel_z),
		.acc_x     (acc_x),
		.acc_y     (acc_y),
		.acc_z     (acc_z),
		.mass      (mass),
		.drag      (drag),
		.tail      (tail)
	);

	// Output stage: normalize drag products, zero fields of expired particles
	logic done_q, alive_q;
	q_t   life_q, pos_x_q, pos_y_q, pos_z_q, vel_x_q, vel_y_q, vel_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		alive_q <= tail.alive;
		life_q  <= tail.life;
		if (tail.alive) begin
			pos_x_q <= tail.pos_x;
			pos_y_q <= tail.pos_y;
			pos_z_q <= tail.pos_z;
			vel_x_q <= qnorm(tail.prod_x);
			vel_y_q <= qnorm(tail.prod_y);
			vel_z_q <= qnorm(tail.prod_z);
		end else begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			pos_z_q <= '0;
			vel_x_q <= '0;
			vel_y_q <= '0;
			vel_z_q <= '0;
		end
	end

	assign done          = done_q;
	assign alive         = alive_q;
	assign new_life_left = life_q;
	assign new_pos_x     = pos_x_q;
	assign new_pos_y     = pos_y_q;
	assign new_pos_z     = pos_z_q;
	assign new_vel_x     = vel_x_q;
	assign new_vel_y     = vel_y_q;
	assign new_vel_z     = vel_z_q;

endmodule

`default_nettype wire

// ===== hdl/pes_cfg.sv =====
// pes_cfg: time step and gravity registers behind the plain write port.
// Depends on pes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pes_cfg
	import pes_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [0:0]            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.time_step     <= DT_W'(1092);
			cfg_q.gravity_accel <= -32'sd642908;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TIME_STEP: cfg_q.time_step     <= cfg_data[DT_W-1:0];
				CFG_GRAVITY:   cfg_q.gravity_accel <= cfg_data;
				default:       ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== hdl/pes_pipe.sv =====
// pes_pipe: stages 1 to 5 of the Euler step datapath (products, sums,
// gravity, drag products). Depends on pes_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pes_pipe
	import pes_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cfg_t cfg,
	input  wire logic in_vld,
	input  wire q_t   life_left,
	input  wire q_t   pos_x,
	input  wire q_t   pos_y,
	input  wire q_t   pos_z,
	input  wire q_t   vel_x,
	input  wire q_t   vel_y,
	input  wire q_t   vel_z,
	input  wire q_t   acc_x,
	input  wire q_t   acc_y,
	input  wire q_t   acc_z,
	input  wire q_t   mass,
	input  wire q_t   drag,
	output tail_t     tail
);

	logic signed [DT_W:0] dt;
	q_t                   life_in;
	q_t                   pos_in [3];
	q_t                   vel_in [3];
	q_t                   acc_in [3];

	assign dt      = $signed({1'b0, cfg.time_step});
	assign life_in = sub_sat(life_left, q_t'({15'd0, cfg.time_step}));
	assign pos_in  = '{pos_x, pos_y, pos_z};
	assign vel_in  = '{vel_x, vel_y, vel_z};
	assign acc_in  = '{acc_x, acc_y, acc_z};

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// S1: life, raw products against dt and gravity
	logic               alive_s1;
	q_t                 life_s1;
	q_t                 pos_s1 [3];
	q_t                 vel_s1 [3];
	logic signed [49:0] pv_s1 [3];
	logic signed [49:0] pa_s1 [3];
	logic signed [63:0] pmg_s1;
	logic signed [49:0] pdd_s1;

	always_ff @(posedge clk) begin
		life_s1  <= life_in;
		alive_s1 <= !life_in[31] && (life_in != '0);
		for (int k = 0; k < 3; k++) begin
			pos_s1[k] <= pos_in[k];
			vel_s1[k] <= vel_in[k];
			pv_s1[k]  <= vel_in[k] * dt;
			pa_s1[k]  <= acc_in[k] * dt;
		end
		pmg_s1 <= mass * cfg.gravity_accel;
		pdd_s1 <= drag * dt;
	end

	// S2: normalize, position and velocity sums, drag factor
	logic alive_s2;
	q_t   life_s2;
	q_t   pos_s2 [3];
	q_t   vel_s2 [3];
	q_t   mg_s2;
	q_t   factor_s2;

	always_ff @(posedge clk) begin
		alive_s2 <= alive_s1;
		life_s2  <= life_s1;
		for (int k = 0; k < 3; k++) begin
			pos_s2[k] <= add_sat(pos_s1[k], qnorm({{14{pv_s1[k][49]}}, pv_s1[k]}));
			vel_s2[k] <= add_sat(vel_s1[k], qnorm({{14{pa_s1[k][49]}}, pa_s1[k]}));
		end
		mg_s2     <= qnorm(pmg_s1);
		factor_s2 <= sub_sat(Q_ONE, qnorm({{14{pdd_s1[49]}}, pdd_s1}));
	end

	// S3: gravity term times dt
	logic               alive_s3;
	q_t                 life_s3;
	q_t                 pos_s3 [3];
	q_t                 vel_s3 [3];
	q_t                 factor_s3;
	logic signed [49:0] pg_s3;

	always_ff @(posedge clk) begin
		alive_s3  <= alive_s2;
		life_s3   <= life_s2;
		pos_s3    <= pos_s2;
		vel_s3    <= vel_s2;
		factor_s3 <= factor_s2;
		pg_s3     <= mg_s2 * dt;
	end

	// S4: add gravity into vertical velocity
	logic alive_s4;
	q_t   life_s4;
	q_t   pos_s4 [3];
	q_t   vel_s4 [3];
	q_t   factor_s4;

	always_ff @(posedge clk) begin
		alive_s4  <= alive_s3;
		life_s4   <= life_s3;
		pos_s4    <= pos_s3;
		factor_s4 <= factor_s3;
		vel_s4[0] <= vel_s3[0];
		vel_s4[1] <= add_sat(vel_s3[1], qnorm({{14{pg_s3[49]}}, pg_s3}));
		vel_s4[2] <= vel_s3[2];
	end

	// S5: drag products
	logic               alive_s5;
	q_t                 life_s5;
	q_t                 pos_s5 [3];
	logic signed [63:0] pf_s5 [3];

	always_ff @(posedge clk) begin
		alive_s5 <= alive_s4;
		life_s5  <= life_s4;
		pos_s5   <= pos_s4;
		for (int k = 0; k < 3; k++) begin
			pf_s5[k] <= vel_s4[k] * factor_s4;
		end
	end

	always_comb begin
		tail.valid  = vld_s5;
		tail.alive  = alive_s5;
		tail.life   = life_s5;
		tail.pos_x  = pos_s5[0];
		tail.pos_y  = pos_s5[1];
		tail.pos_z  = pos_s5[2];
		tail.prod_x = pf_s5[0];
		tail.prod_y = pf_s5[1];
		tail.prod_z = pf_s5[2];
	end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// testbench: streams particles through particle_euler_step_top and checks every
// result word against a Q16.16 Euler step predictor held in a scoreboard class.
// Depends on pes_pkg and the particle_euler_step_top RTL.
`timescale 1ns / 1ps

module testbench;
	import pes_pkg::*;

	// Pipeline depth from the top-level header; used only for settle pauses
	localparam int LATENCY     = 6;
	// Cycles with no word moving on either side before the run is declared hung
	localparam int STALL_LIMIT = 2000;

	// One particle word; life is the first field and so sits in the top bits
	typedef struct packed {
		q_t life;
		q_t px, py, pz;
		q_t vx, vy, vz;
		q_t ax, ay, az;
		q_t mass;
		q_t drag;
	} particle_t;

	// One result word
	typedef struct packed {
		logic alive;
		q_t   life;
		q_t   px, py, pz;
		q_t   vx, vy, vz;
	} stepped_t;

	// Register shadow, Euler step predictor and the queue of stepped particles
	// still to come out of the block.
	class euler_scoreboard;
		logic [DT_W-1:0] dt      = 17'd1092;
		q_t              gravity = -32'sd642908;
		stepped_t        stepped_q[$];
		int              fails   = 0;
		int              seen    = 0;
		int              expired = 0;

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_TIME_STEP: dt = data[DT_W-1:0];
				CFG_GRAVITY:   gravity = data;
				default: ;
			endcase
		endfunction

		function q_t clamp(longint v);
			if (v > longint'(Q_MAX))
				return Q_MAX;
			if (v < longint'(Q_MIN))
				return Q_MIN;
			return q_t'(v);
		endfunction

		// Q16.16 product, floored, then clamped
		function q_t fx_mul(q_t a, q_t b);
			longint prod;
			prod = longint'(a) * longint'(b);
			return clamp(prod >>> FRAC_W);
		endfunction

		function stepped_t advance(particle_t p);
			stepped_t r;
			q_t       step_q;
			q_t       factor;
			q_t       pos[3];
			q_t       vel[3];
			q_t       acc[3];
			int       k;
			r = '0;
			step_q = $signed({15'd0, dt});
			r.life = clamp(longint'(p.life) - longint'(step_q));
			// expired: only the remaining life is reported, the rest stays zero
			if (r.life <= 0)
				return r;
			pos = '{p.px, p.py, p.pz};
			vel = '{p.vx, p.vy, p.vz};
			acc = '{p.ax, p.ay, p.az};
			// position moves with the velocity from before this step
			for (k = 0; k < 3; k++) begin
				pos[k] = clamp(longint'(pos[k]) + longint'(fx_mul(vel[k], step_q)));
				vel[k] = clamp(longint'(vel[k]) + longint'(fx_mul(acc[k], step_q)));
			end
			vel[1] = clamp(longint'(vel[1])
				+ longint'(fx_mul(fx_mul(p.mass, gravity), step_q)));
			factor = clamp(longint'(Q_ONE) - longint'(fx_mul(p.drag, step_q)));
			for (k = 0; k < 3; k++)
				vel[k] = fx_mul(vel[k], factor);
			r.alive = 1'b1;
			{r.px, r.py, r.pz} = {pos[0], pos[1], pos[2]};
			{r.vx, r.vy, r.vz} = {vel[0], vel[1], vel[2]};
			return r;
		endfunction

		function void note_particle(particle_t p);
			stepped_q = {stepped_q, advance(p)};
		endfunction

		function void match(string name, q_t want, q_t got);
			if (want !== got) begin
				fails++;
				$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_result(stepped_t got);
			stepped_t want;
			if (stepped_q.size() == 0) begin
				fails++;
				$error("result word with no particle in flight");
				return;
			end
			want = stepped_q.pop_front();
			seen++;
			if (!want.alive)
				expired++;
			if (want.alive !== got.alive) begin
				fails++;
				$error("alive: expected %0d, got %0d", want.alive, got.alive);
			end
			match("new_life_left", want.life, got.life);
			match("new_pos_x", want.px, got.px);
			match("new_pos_y", want.py, got.py);
			match("new_pos_z", want.pz, got.pz);
			match("new_vel_x", want.vx, got.vx);
			match("new_vel_y", want.vy, got.vy);
			match("new_vel_z", want.vz, got.vz);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [0:0]            cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  start     = 1'b0;
	logic                  busy;
	q_t                    life_left = '0;
	q_t                    pos_x = '0, pos_y = '0, pos_z = '0;
	q_t                    vel_x = '0, vel_y = '0, vel_z = '0;
	q_t                    acc_x = '0, acc_y = '0, acc_z = '0;
	q_t                    mass  = '0;
	q_t                    drag  = '0;
	logic                  done;
	logic                  alive;
	q_t                    new_life_left;
	q_t                    new_pos_x, new_pos_y, new_pos_z;
	q_t                    new_vel_x, new_vel_y, new_vel_z;

	euler_scoreboard sb = new();

	// Set at each rising edge, read by the driver at the following falling edge
	logic took_word   = 1'b0;
	int   quiet_cycles = 0;

	particle_euler_step_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: everything is sampled at the rising edge, before the block's
	// registers update, so input acceptance and result words are seen as the
	// block sees them.
	always @(posedge clk) begin
		took_word = start && !busy;
		if (arst_n) begin
			if (took_word)
				sb.note_particle(particle_t'{life_left, pos_x, pos_y, pos_z,
					vel_x, vel_y, vel_z, acc_x, acc_y, acc_z, mass, drag});
			// done is a one-cycle strobe; the word is gone after this edge
			if (done)
				sb.check_result(stepped_t'{alive, new_life_left, new_pos_x,
					new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z});
			if (took_word || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	// Watchdog: nothing moving for too long means the block has hung
	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("[particle_euler_step_top] ERROR");
		$finish;
	end

	// Drive one particle word and hold it until the block takes it. The sender
	// idles for idle_pct percent of the cycles before each word.
	task automatic send_particle(particle_t p, int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		{life_left, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
			acc_x, acc_y, acc_z, mass, drag} <= p;
		do
			@(negedge clk);
		while (!took_word);
	endtask

	// Let every particle in flight come out, then give the pipe time to settle
	task automatic drain();
		start <= 1'b0;
		while (sb.stepped_q.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	function automatic q_t any_q();
		case ($urandom_range(7))
			0: return Q_MIN;
			1: return Q_MAX;
			2: return '0;
			3: return -32'sd1;
			4: return Q_ONE;
			default: return $urandom;
		endcase
	endfunction

	// Uniform draw in [-span, span]
	function automatic q_t near(int span);
		return q_t'($urandom_range(0, 2 * span)) - span;
	endfunction

	// Same value in every field but life
	function automatic particle_t fill(q_t life, q_t v);
		particle_t p;
		p = {12{v}};
		p.life = life;
		return p;
	endfunction

	function automatic particle_t random_particle();
		particle_t p;
		q_t        step_q;
		int        kind;
		int        i;
		step_q = $signed({15'd0, sb.dt});
		kind = $urandom_range(99);
		if (kind < 65) begin
			// plausible particle that survives the step
			p.life = step_q + 1 + q_t'($urandom_range(0, 1 << 21));
			p.px = near(1 << 24);
			p.py = near(1 << 24);
			p.pz = near(1 << 24);
			p.vx = near(1 << 22);
			p.vy = near(1 << 22);
			p.vz = near(1 << 22);
			p.ax = near(1 << 20);
			p.ay = near(1 << 20);
			p.az = near(1 << 20);
			p.mass = $urandom_range(0, 4 * 65536);
			p.drag = ($urandom_range(9) == 0) ? near(1 << 18) : $urandom_range(0, 2 * 65536);
		end else if (kind < 80) begin
			for (i = 0; i < 12; i++)
				p[i*32 +: 32] = $urandom;
		end else begin
			for (i = 0; i < 12; i++)
				p[i*32 +: 32] = any_q();
			// around the life boundary: a couple of lsbs either side of one step
			if (kind < 90)
				p.life = step_q + near(2);
		end
		return p;
	endfunction

	// Hand-picked particles under the reset register values
	task automatic run_directed();
		particle_t p;
		p = fill(Q_MAX, '0);
		send_particle(p, 0);
		// life of exactly one step lands on zero and expires
		p.life = 32'sd1092;
		send_particle(p, 0);
		p.life = 32'sd1093;
		send_particle(p, 0);
		// remaining life clamps at the bottom
		p.life = Q_MIN;
		send_particle(p, 0);
		// expired particle with busy fields: they must come back as zero
		send_particle(fill('0, Q_MAX), 0);
		send_particle(fill(Q_MAX, Q_MAX), 0);
		send_particle(fill(Q_MAX, Q_MIN), 0);
		p = fill(Q_MAX, '0);
		{p.px, p.py, p.pz, p.vx, p.vy, p.vz} = {6{Q_MIN}};
		send_particle(p, 0);
		// velocity plus acceleration overflowing both ways
		p = fill(Q_MAX, '0);
		{p.vx, p.vy, p.vz, p.ax, p.ay, p.az} = {Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX};
		send_particle(p, 0);
		// negative drag blows the drag factor up
		p = fill(Q_MAX, Q_ONE);
		p.drag = Q_MIN;
		send_particle(p, 0);
		// mass times gravity clamping in each direction
		p = fill(Q_MAX, '0);
		p.mass = Q_MAX;
		send_particle(p, 0);
		p.mass = Q_MIN;
		send_particle(p, 0);
		// tiny negative products round toward minus infinity
		p = fill(32'sd65536, '0);
		{p.vx, p.vy, p.vz} = {-32'sd1, 32'sd1, -32'sd65536};
		send_particle(p, 0);
		// an ordinary particle
		p.life = 32'sd131072;
		{p.px, p.py, p.pz} = {32'sd65536, 32'sd131072, 32'sd196608};
		{p.vx, p.vy, p.vz} = {32'sd655360, -32'sd327680, 32'sd32768};
		{p.ax, p.ay, p.az} = {32'sd0, -32'sd65536, 32'sd0};
		p.mass = 32'sd65536;
		p.drag = 32'sd32768;
		send_particle(p, 0);
		// strong drag: factor well below one
		p.drag = 32'sd3932160;
		send_particle(p, 0);
	endtask

	// One register setting, then count random particles at the given idle rate
	task automatic run_phase(logic [CFG_DATA_W-1:0] dt_word,
			logic [CFG_DATA_W-1:0] grav_word, int idle_pct, int count);
		drain();
		write_reg(CFG_TIME_STEP, dt_word);
		write_reg(CFG_GRAVITY, grav_word);
		repeat (count) send_particle(random_particle(), idle_pct);
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		run_directed();

		run_phase(32'd1092, -32'sd642908, 0, 300);
		run_phase(32'd65536, Q_MAX, 87, 250);
		run_phase(32'd0, Q_MIN, 7, 250);
		// upper bits are dropped: time step becomes 131071, just under 2.0
		run_phase(32'hFFFF_FFFF, 32'd0, 0, 250);
		run_phase(32'd1, $urandom, 87, 250);
		run_phase({15'($urandom), 17'($urandom_range(0, 131071))}, $urandom, 7, 250);
		run_phase(32'd4370, -32'sd642908, 0, 300);
		drain();

		$display("Stepped %0d particles (%0d expired) over the reset and seven written",
			sb.seen, sb.expired);
		$display("register settings, with idle-free and idle-heavy input phases.");
		if (sb.fails == 0)
			$display("[particle_euler_step_top] OK");
		else
			$display("[particle_euler_step_top] ERROR");
		$finish;
	end

endmodule
